### design/swsc_pkg.sv
// ----------------------------------------------------------------------------
// swsc_pkg: shared types for the go-back-n sender window control
// Field widths, opcode and result kinds, FSM states, controller/datapath bus.
// ----------------------------------------------------------------------------
`default_nettype none

package swsc_pkg;

  localparam int unsigned MaxPackets = 1024; // bitmap depth and cap on the total
  localparam int unsigned TotalW    = 11;  // total_packets, window_base, counters
  localparam int unsigned WinW      = 5;   // window length register
  localparam int unsigned SeqW      = 10;  // seq_number, ack_number
  localparam int unsigned KindW     = 3;
  localparam int unsigned OpW       = 2;
  localparam int unsigned InDataW   = 16;  // ack_number padded to bytes
  localparam int unsigned OutDataW  = 24;  // seq_number + window_base padded to bytes
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 11;

  localparam logic [CfgIdxW-1:0] RegTotal  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWindow = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_FILL    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_SEND        = 3'd0,
    KIND_ACK_TAKEN   = 3'd1,
    KIND_ACK_IGNORED = 3'd2,
    KIND_DONE        = 3'd3,
    KIND_NOTHING     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_ACK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_RESP_ACK,
    ST_RESP_IGN,
    ST_RESP_NOP
  } state_e;

  typedef struct packed {
    logic  accept;      // latch the request
    logic  rewind;      // next = base
    logic  clear;       // write one zero of the clearing pass
    logic  mark;        // set the acked bit of the latched ack
    logic  base_inc;
    logic  next_inc;
    logic  raise_next;  // next = max(next, base)
    logic  emit;        // load the result register
    kind_e kind;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic can_send;
    logic last_send;
    logic ack_oor;
    logic base_lt_total;
    logic map_bit;
    logic slot_free;
  } status_t;

endpackage

`default_nettype wire

### design/sliding_window_sender_control_top.sv
// ----------------------------------------------------------------------------
// sliding_window_sender_control_top: go-back-n sender window control
// Takes fill, ack and timeout requests and streams out the results.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  --------  ---------  -----------------------------------------------------
//  s_axis    in         tuser = opcode, tdata = ack_number
//  m_axis    out        tuser = kind, tdata = seq_number, window_base; tlast = last
//  cfg       in         write of total_packets (index 0) or the window length (1)
//
//  After reset the acked bitmap is cleared one entry a cycle; no request is
//  taken before the last entry is cleared (config writes work then).
//  One request at a time: fill or timeout gives 1 to MaxWindow results, an
//  unknown opcode one result of kind nothing, an ack one result: ignored
//  when out of range, else taken once the base has advanced over the acked
//  packets (done at the total). A stall on m_axis holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender_control_top #(
  parameter int unsigned MaxWindow  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [swsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [swsc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // request stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [swsc_pkg::InDataW-1:0]  s_axis_tdata,  // [9:0] ack_number
  input  wire logic [swsc_pkg::OpW-1:0]      s_axis_tuser,  // [1:0] opcode
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [9:0] seq_number, [20:10] window_base
  output logic      [swsc_pkg::OutDataW-1:0] m_axis_tdata,
  output logic      [swsc_pkg::KindW-1:0]    m_axis_tuser,  // [2:0] kind
  output logic                               m_axis_tlast
);

  import swsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller: sequences each request and drives the datapath commands
  swsc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_op_i   (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // datapath: window pointers, acked bitmap, result register
  swsc_dp #(
    .MaxWindow (MaxWindow)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (s_axis_tdata),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .out_kind_o (m_axis_tuser),
    .out_last_o (m_axis_tlast),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

`default_nettype wire

### design/swsc_ram.sv
// ----------------------------------------------------------------------------
// swsc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swsc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### design/swsc_ctrl.sv
// ----------------------------------------------------------------------------
// swsc_ctrl: sender window controller
// Sequences clearing, fill, ack walk and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module swsc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic [swsc_pkg::OpW-1:0] in_op_i,
  output logic                       in_ready_o,
  input  wire swsc_pkg::status_t     status_i,
  output swsc_pkg::cmd_t             cmd_o
);

  import swsc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(in_op_i))
            OP_FILL:    state_d = ST_FILL;
            OP_TIMEOUT: state_d = ST_FILL;
            OP_ACK:     state_d = ST_ACK;
            default:    state_d = ST_RESP_NOP;
          endcase
        end
      end
      ST_FILL: begin
        if (status_i.slot_free && (!status_i.can_send || status_i.last_send)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ACK: begin
        state_d = status_i.ack_oor ? ST_RESP_IGN : ST_WALK_RD;
      end
      ST_WALK_RD: begin
        state_d = status_i.base_lt_total ? ST_WALK_CHK : ST_RESP_ACK;
      end
      ST_WALK_CHK: begin
        state_d = status_i.map_bit ? ST_WALK_RD : ST_RESP_ACK;
      end
      ST_RESP_ACK, ST_RESP_IGN, ST_RESP_NOP: begin
        if (status_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = KIND_NOTHING;
    cmd_o.last = 1'b1;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        cmd_o.rewind = in_valid_i && (op_e'(in_op_i) == OP_TIMEOUT);
      end
      ST_FILL: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.can_send) begin
            cmd_o.kind     = KIND_SEND;
            cmd_o.last     = status_i.last_send;
            cmd_o.next_inc = 1'b1;
          end
        end
      end
      ST_ACK: begin
        cmd_o.mark = !status_i.ack_oor;
      end
      ST_WALK_CHK: begin
        cmd_o.base_inc = status_i.map_bit;
      end
      ST_RESP_ACK: begin
        if (status_i.slot_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.raise_next = 1'b1;
          cmd_o.kind       = status_i.base_lt_total ? KIND_ACK_TAKEN : KIND_DONE;
        end
      end
      ST_RESP_IGN: begin
        cmd_o.emit = status_i.slot_free;
        cmd_o.kind = KIND_ACK_IGNORED;
      end
      ST_RESP_NOP: begin
        cmd_o.emit = status_i.slot_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### design/swsc_dp.sv
// ----------------------------------------------------------------------------
// swsc_dp: sender window datapath
// Window pointers, config registers, acked bitmap and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swsc_dp #(
  parameter int unsigned MaxWindow  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [swsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [swsc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic [swsc_pkg::InDataW-1:0]  in_data_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic      [swsc_pkg::OutDataW-1:0] out_data_o,
  output logic      [swsc_pkg::KindW-1:0]    out_kind_o,
  output logic                               out_last_o,
  input  wire swsc_pkg::cmd_t                cmd_i,
  output swsc_pkg::status_t                  status_o
);

  import swsc_pkg::*;

  localparam int unsigned IdxW    = $clog2(MaxPackets);
  localparam int unsigned WinEffW = $clog2(MaxWindow + 1);
  localparam int unsigned SumW    = TotalW + 1;

  logic [TotalW-1:0]   total_q, total_d;
  logic [WinW-1:0]     win_q, win_d;
  logic [TotalW-1:0]   base_q, base_d;
  logic [TotalW-1:0]   next_q, next_d;
  logic [SeqW-1:0]     ack_q, ack_d;
  logic [IdxW-1:0]     clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [KindW-1:0]    out_kind_q, out_kind_d;
  logic                out_last_q, out_last_d;

  logic [TotalW-1:0]  total_eff;
  logic [WinEffW-1:0] win_eff;
  logic [SumW-1:0]    limit, stop;
  logic [SeqW-1:0]    seq_out;
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic               ram_rdata;

  always_comb begin
    if (32'(total_q) < MaxPackets) total_eff = total_q;
    else                           total_eff = TotalW'(MaxPackets);
    if (32'(win_q) < MaxWindow) win_eff = WinEffW'(win_q);
    else                        win_eff = WinEffW'(MaxWindow);
    limit = SumW'(base_q) + SumW'(win_eff);
    stop  = (limit < SumW'(total_eff)) ? limit : SumW'(total_eff);
  end

  always_comb begin
    status_o.clear_done    = (clr_q == IdxW'(MaxPackets - 1));
    status_o.can_send      = SumW'(next_q) < stop;
    status_o.last_send     = (SumW'(next_q) + SumW'(1)) >= stop;
    status_o.ack_oor       = TotalW'(ack_q) >= total_eff;
    status_o.base_lt_total = base_q < total_eff;
    status_o.map_bit       = ram_rdata;
    status_o.slot_free     = !out_valid_q || out_ready_i;
  end

  assign ram_we    = cmd_i.clear || cmd_i.mark;
  assign ram_waddr = cmd_i.clear ? clr_q : IdxW'(ack_q);

  swsc_ram #(
    .Width(1),
    .Depth(MaxPackets)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(!cmd_i.clear),
    .raddr_i(IdxW'(base_q)),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    total_d = total_q;
    win_d   = win_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegTotal:  total_d = cfg_wdata_i;
        RegWindow: win_d   = cfg_wdata_i[WinW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    base_d = base_q;
    next_d = next_q;
    ack_d  = ack_q;
    clr_d  = clr_q;
    if (cmd_i.accept) ack_d = in_data_i[SeqW-1:0];
    if (cmd_i.rewind) next_d = base_q;
    if (cmd_i.next_inc) next_d = next_q + TotalW'(1);
    if (cmd_i.base_inc) base_d = base_q + TotalW'(1);
    if (cmd_i.raise_next && (next_q < base_q)) next_d = base_q;
    if (cmd_i.clear) clr_d = clr_q + IdxW'(1);
  end

  assign seq_out = (cmd_i.kind == KIND_SEND) ? next_q[SeqW-1:0] : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_data_d  = OutDataW'({base_q, seq_out});
      out_kind_d  = cmd_i.kind;
      out_last_d  = cmd_i.last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TotalW'(10);
      win_q       <= WinW'(4);
      base_q      <= '0;
      next_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      win_q       <= win_d;
      base_q      <= base_d;
      next_q      <= next_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ack_q      <= ack_d;
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

### design/swsc_checker.sv
// ----------------------------------------------------------------------------
// swsc_checker: port-level checks for the sender window control
// Watches the result and request streams of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swsc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [swsc_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic [swsc_pkg::KindW-1:0]    m_axis_tuser,
  input wire logic                          m_axis_tlast
);

  import swsc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed under stall");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in work");

  // anything but a send is a single, final result
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_SEND) |-> m_axis_tlast)
    else $error("non-send result without tlast");

  // sequence number only carried by sends
  a_seq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_SEND) |-> m_axis_tdata[9:0] == '0)
    else $error("non-send result with sequence number");

endmodule

bind sliding_window_sender_control_top swsc_checker u_swsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
